[sv/lobm_pkg.sv]
// Package for the limit order book matcher: item types, codes and helpers.
`timescale 1ns / 1ps
`default_nettype none
package lobm_pkg;

    localparam logic [1:0] CMD_SUBMIT = 2'd0;
    localparam logic [1:0] CMD_AMEND  = 2'd1;
    localparam logic [1:0] CMD_CANCEL = 2'd2;

    localparam logic [2:0] ST_ACCEPTED   = 3'd0;
    localparam logic [2:0] ST_REJECTED   = 3'd1;
    localparam logic [2:0] ST_REPL_KEPT  = 3'd2;
    localparam logic [2:0] ST_REPL_RESET = 3'd3;
    localparam logic [2:0] ST_CANCELED   = 3'd4;
    localparam logic [2:0] ST_FILL       = 3'd5;
    localparam logic [2:0] ST_RESTING    = 3'd6;

    localparam logic [2:0] RSN_NONE      = 3'd0;
    localparam logic [2:0] RSN_SYMBOL    = 3'd1;
    localparam logic [2:0] RSN_NONPOS    = 3'd2;
    localparam logic [2:0] RSN_DUPLICATE = 3'd3;
    localparam logic [2:0] RSN_NOT_FOUND = 3'd4;
    localparam logic [2:0] RSN_BELOW     = 3'd5;
    localparam logic [2:0] RSN_FULL      = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_DEC,
        S_BEST,
        S_MDEC,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic [1:0]         command;
        logic [15:0]        symbol_code;
        logic [31:0]        ord_ref;
        logic               side;
        logic signed [31:0] price;
        logic [31:0]        quantity;
    } t_cmd;

    typedef struct packed {
        logic [2:0]         status;
        logic [2:0]         reject_reason;
        logic [31:0]        report_order_id;
        logic [31:0]        contra_order_id;
        logic               report_side;
        logic signed [31:0] order_price;
        logic [30:0]        exec_price;
        logic [31:0]        exec_qty;
        logic [31:0]        cum_qty;
        logic [31:0]        open_qty;
        logic [31:0]        contra_leaves;
        logic               last;
    } t_res;

    typedef struct packed {
        logic [31:0]        id;
        logic               side;
        logic signed [31:0] price;
        logic [31:0]        qty;
        logic [31:0]        leaves;
    } t_ord;

    typedef struct packed {
        logic [31:0]        id;
        logic               side;
        logic signed [31:0] price;
        logic [31:0]        qty;
        logic [31:0]        leaves;
        logic [63:0]        stamp;
    } t_slot;

    function automatic logic [31:0] filled_of(input logic [31:0] qty,
                                              input logic [31:0] leaves);
        filled_of = (qty >= leaves) ? qty - leaves : 32'd0;
    endfunction

    function automatic t_res ord_rec(input logic [2:0] status,
                                     input logic [2:0] reason, input t_ord o);
        t_res r;
        r = '0;
        r.status          = status;
        r.reject_reason   = reason;
        r.report_order_id = o.id;
        r.report_side     = o.side;
        r.order_price     = o.price;
        r.cum_qty         = filled_of(o.qty, o.leaves);
        r.open_qty        = o.leaves;
        ord_rec = r;
    endfunction

    function automatic t_ord slot_ord(input t_slot s);
        t_ord o;
        o.id     = s.id;
        o.side   = s.side;
        o.price  = s.price;
        o.qty    = s.qty;
        o.leaves = s.leaves;
        slot_ord = o;
    endfunction

endpackage
`default_nettype wire

[sv/limit_order_book_matcher.sv]
// Limit order book matcher top level: slot memory, scan sequencer, result register.
// Each command scans all ORDER_SLOTS slots and then decodes, and each match pass scans them
// again (one pass per fill or rest attempt), followed by a single flush.
// Results leave at most one per cycle, each strobed by o_result_valid; the receiver cannot stall.
// busy drops in the cycle that shows the final result (last=1); a new item may start then.
// Reset clears slot valid bits, the arrival counter, the symbol register and control.
`timescale 1ns / 1ps
`default_nettype none
module limit_order_book_matcher #(
    parameter int ORDER_SLOTS = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire lobm_pkg::t_cmd i_cmd,
    input  wire logic          i_cfg_we,
    input  wire logic [15:0]   i_cfg_data,
    output logic               o_result_valid,
    output lobm_pkg::t_res     o_result
);
    import lobm_pkg::*;

    localparam int IW = $clog2(ORDER_SLOTS);
    localparam int CW = $clog2(ORDER_SLOTS + 1);
    localparam logic [CW-1:0] ScanEnd = CW'(ORDER_SLOTS);
    localparam logic [IW-1:0] LastIdx = IW'(ORDER_SLOTS - 1);

    t_state r_state, n_state;
    logic [15:0] r_sym;
    t_cmd r_cmd, n_cmd;
    logic [ORDER_SLOTS-1:0] r_valid, n_valid;
    logic [63:0] r_counter, n_counter;
    logic [CW-1:0] r_addr, n_addr;
    logic r_rd_ok, n_rd_ok;
    logic [IW-1:0] r_rd_idx, n_rd_idx;
    t_slot r_rd;
    logic r_hit, n_hit;
    logic [IW-1:0] r_hit_idx, n_hit_idx;
    t_slot r_hit_e, n_hit_e;
    logic r_bst_v, n_bst_v;
    logic [IW-1:0] r_bst_idx, n_bst_idx;
    t_slot r_bst_e, n_bst_e;
    logic r_free_v, n_free_v;
    logic [IW-1:0] r_free_idx, n_free_idx;
    t_ord r_agg, n_agg;
    logic r_matched, n_matched;
    logic r_pend_v, n_pend_v;
    t_res r_pend, n_pend;
    logic r_out_v, n_out_v;
    t_res r_out, n_out;

    t_slot mem [ORDER_SLOTS];
    logic rd_en;
    logic we;
    logic [IW-1:0] waddr;
    t_slot wdata;
    logic push;
    t_res push_rec;

    // shared decode
    logic scan_last;
    logic cmd_nonpos;
    logic [31:0] hit_done;
    t_ord in_ord, hit_ord;
    logic crosses;
    logic [31:0] fq, agg_left, bst_left;
    logic better;

    assign scan_last  = r_rd_ok && (r_rd_idx == LastIdx);
    assign cmd_nonpos = (r_cmd.quantity == 32'd0) || (r_cmd.price <= 32'sd0);
    assign hit_ord    = slot_ord(r_hit_e);
    assign hit_done   = filled_of(r_hit_e.qty, r_hit_e.leaves);
    assign in_ord     = '{id: r_cmd.ord_ref, side: r_cmd.side, price: r_cmd.price,
                          qty: r_cmd.quantity, leaves: r_cmd.quantity};
    assign crosses    = r_bst_v && (r_agg.side == 1'b0 ? !(r_agg.price < r_bst_e.price)
                                                       : !(r_agg.price > r_bst_e.price));
    assign fq         = (r_agg.leaves < r_bst_e.leaves) ? r_agg.leaves : r_bst_e.leaves;
    assign agg_left   = r_agg.leaves - fq;
    assign bst_left   = r_bst_e.leaves - fq;

    always_comb begin
        better = 1'b0;
        if (!r_bst_v) begin
            better = 1'b1;
        end else if (r_rd.price == r_bst_e.price) begin
            better = r_rd.stamp < r_bst_e.stamp;
        end else if (r_agg.side == 1'b0) begin
            better = r_rd.price < r_bst_e.price;
        end else begin
            better = r_rd.price > r_bst_e.price;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start && (i_cmd.command == CMD_SUBMIT || i_cmd.command == CMD_AMEND ||
                              i_cmd.command == CMD_CANCEL)) begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                if (scan_last) n_state = S_DEC;
            end
            S_DEC: begin
                n_state = S_FLUSH;
                case (r_cmd.command)
                    CMD_SUBMIT: begin
                        if (r_cmd.symbol_code == r_sym && !cmd_nonpos && !r_hit)
                            n_state = S_BEST;
                    end
                    CMD_AMEND: begin
                        if (r_hit && !cmd_nonpos && (r_cmd.quantity > hit_done) &&
                            !(r_cmd.price == r_hit_e.price && r_cmd.quantity <= r_hit_e.qty))
                            n_state = S_BEST;
                    end
                    default: n_state = S_FLUSH;
                endcase
            end
            S_BEST: begin
                if (scan_last) n_state = S_MDEC;
            end
            S_MDEC: begin
                if (crosses && agg_left != 32'd0) n_state = S_BEST;
                else n_state = S_FLUSH;
            end
            S_FLUSH: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_cmd      = r_cmd;
        n_valid    = r_valid;
        n_counter  = r_counter;
        n_addr     = r_addr;
        n_rd_ok    = 1'b0;
        n_rd_idx   = r_addr[IW-1:0];
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_hit_e    = r_hit_e;
        n_bst_v    = r_bst_v;
        n_bst_idx  = r_bst_idx;
        n_bst_e    = r_bst_e;
        n_free_v   = r_free_v;
        n_free_idx = r_free_idx;
        n_agg      = r_agg;
        n_matched  = r_matched;
        n_pend_v   = r_pend_v;
        n_pend     = r_pend;
        n_out_v    = 1'b0;
        n_out      = r_out;
        rd_en      = 1'b0;
        we         = 1'b0;
        waddr      = r_hit_idx;
        wdata      = r_hit_e;
        push       = 1'b0;
        push_rec   = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd   = i_cmd;
                    n_addr  = '0;
                    n_hit   = 1'b0;
                end
            end
            S_FIND, S_BEST: begin
                rd_en = r_addr != ScanEnd;
                if (rd_en) n_addr = r_addr + CW'(1);
                n_rd_ok = rd_en;
                if (r_rd_ok) begin
                    if (r_state == S_FIND) begin
                        if (r_valid[r_rd_idx] && r_rd.id == r_cmd.ord_ref && !r_hit) begin
                            n_hit     = 1'b1;
                            n_hit_idx = r_rd_idx;
                            n_hit_e   = r_rd;
                        end
                    end else if (!r_valid[r_rd_idx]) begin
                        if (!r_free_v) begin
                            n_free_v   = 1'b1;
                            n_free_idx = r_rd_idx;
                        end
                    end else if (r_rd.side != r_agg.side && better) begin
                        n_bst_v   = 1'b1;
                        n_bst_idx = r_rd_idx;
                        n_bst_e   = r_rd;
                    end
                end
            end
            S_DEC: begin
                n_addr    = '0;
                n_bst_v   = 1'b0;
                n_free_v  = 1'b0;
                n_matched = 1'b0;
                push      = 1'b1;
                case (r_cmd.command)
                    CMD_SUBMIT: begin
                        if (r_cmd.symbol_code != r_sym) begin
                            push_rec = ord_rec(ST_REJECTED, RSN_SYMBOL, in_ord);
                        end else if (cmd_nonpos) begin
                            push_rec = ord_rec(ST_REJECTED, RSN_NONPOS, in_ord);
                        end else if (r_hit) begin
                            push_rec = ord_rec(ST_REJECTED, RSN_DUPLICATE, in_ord);
                        end else begin
                            push_rec = ord_rec(ST_ACCEPTED, RSN_NONE, in_ord);
                            n_agg    = in_ord;
                        end
                    end
                    default: begin
                        if (!r_hit) begin
                            push_rec = '0;
                            push_rec.status          = ST_REJECTED;
                            push_rec.reject_reason   = RSN_NOT_FOUND;
                            push_rec.report_order_id = r_cmd.ord_ref;
                        end else if (r_cmd.command == CMD_CANCEL) begin
                            n_valid[r_hit_idx] = 1'b0;
                            push_rec = ord_rec(ST_CANCELED, RSN_NONE, hit_ord);
                        end else if (cmd_nonpos) begin
                            push_rec = ord_rec(ST_REJECTED, RSN_NONPOS, hit_ord);
                        end else if (r_cmd.quantity <= hit_done) begin
                            push_rec = ord_rec(ST_REJECTED, RSN_BELOW, hit_ord);
                        end else if (r_cmd.price == r_hit_e.price &&
                                     r_cmd.quantity <= r_hit_e.qty) begin
                            we           = 1'b1;
                            wdata.qty    = r_cmd.quantity;
                            wdata.leaves = r_cmd.quantity - hit_done;
                            push_rec     = ord_rec(ST_REPL_KEPT, RSN_NONE, slot_ord(wdata));
                        end else begin
                            n_valid[r_hit_idx] = 1'b0;
                            n_agg        = hit_ord;
                            n_agg.qty    = r_cmd.quantity;
                            n_agg.leaves = r_cmd.quantity - hit_done;
                            n_agg.price  = r_cmd.price;
                            push_rec     = ord_rec(ST_REPL_RESET, RSN_NONE, n_agg);
                        end
                    end
                endcase
            end
            S_MDEC: begin
                n_addr   = '0;
                n_bst_v  = 1'b0;
                n_free_v = 1'b0;
                if (crosses) begin
                    we           = 1'b1;
                    waddr        = r_bst_idx;
                    wdata        = r_bst_e;
                    wdata.leaves = bst_left;
                    if (bst_left == 32'd0) n_valid[r_bst_idx] = 1'b0;
                    n_agg.leaves = agg_left;
                    n_matched    = 1'b1;
                    push         = 1'b1;
                    push_rec     = ord_rec(ST_FILL, RSN_NONE, n_agg);
                    push_rec.contra_order_id = r_bst_e.id;
                    push_rec.exec_price      = r_bst_e.price[30:0];
                    push_rec.exec_qty        = fq;
                    push_rec.contra_leaves   = bst_left;
                end else if (r_free_v) begin
                    we                  = 1'b1;
                    waddr               = r_free_idx;
                    wdata               = '{id: r_agg.id, side: r_agg.side,
                                            price: r_agg.price, qty: r_agg.qty,
                                            leaves: r_agg.leaves, stamp: r_counter};
                    n_valid[r_free_idx] = 1'b1;
                    n_counter           = r_counter + 64'd1;
                    push                = r_matched;
                    push_rec            = ord_rec(ST_RESTING, RSN_NONE, r_agg);
                end else begin
                    push     = 1'b1;
                    push_rec = ord_rec(ST_REJECTED, RSN_FULL, r_agg);
                end
            end
            S_FLUSH: begin
                n_out_v   = 1'b1;
                n_out     = r_pend;
                n_out.last = 1'b1;
                n_pend_v  = 1'b0;
            end
            default: ;
        endcase

        if (push) begin
            if (r_pend_v) begin
                n_out_v = 1'b1;
                n_out   = r_pend;
            end
            n_pend   = push_rec;
            n_pend_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        if (rd_en) r_rd <= mem[r_addr[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sym     <= '0;
            r_valid   <= '0;
            r_counter <= '0;
            r_rd_ok   <= 1'b0;
            r_pend_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_state   <= n_state;
            if (i_cfg_we) r_sym <= i_cfg_data;
            r_valid   <= n_valid;
            r_counter <= n_counter;
            r_rd_ok   <= n_rd_ok;
            r_pend_v  <= n_pend_v;
            r_out_v   <= n_out_v;
        end
        r_cmd      <= n_cmd;
        r_addr     <= n_addr;
        r_rd_idx   <= n_rd_idx;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_hit_e    <= n_hit_e;
        r_bst_v    <= n_bst_v;
        r_bst_idx  <= n_bst_idx;
        r_bst_e    <= n_bst_e;
        r_free_v   <= n_free_v;
        r_free_idx <= n_free_idx;
        r_agg      <= n_agg;
        r_matched  <= n_matched;
        r_pend     <= n_pend;
        r_out      <= n_out;
    end

    assign busy           = r_state != S_IDLE;
    assign o_result_valid = r_out_v;
    assign o_result       = r_out;

endmodule
`default_nettype wire
